FILE: hdl/assert_macros.svh
// Assertion helpers: real checks in simulation, nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMP(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// Next-cycle implication.
`define ASSERT_NXT(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(lbl, c, r, ante, cons)
`define ASSERT_NXT(lbl, c, r, ante, cons)
`endif

`endif

FILE: hdl/efla_pkg.sv
package efla_pkg;

	localparam int ACT_W     = 3;
	localparam int OFF_W     = 24;
	localparam int IDX_W     = 8;
	localparam int BS_W      = 16;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_REINIT = 3'd0,
		ACT_ALLOC  = 3'd1,
		ACT_FREE   = 3'd2,
		ACT_CHECK  = 3'd3,
		ACT_QUERY  = 3'd4
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_BADOFF = 2'd2
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

	typedef struct packed {
		logic             done;
		logic             exact;
		logic [OFF_W-1:0] quo;
	} div_res_t;

endpackage

FILE: hdl/efla_div.sv
// Restoring divider, one quotient bit per cycle.
module efla_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [efla_pkg::OFF_W-1:0]  dividend,
	input  logic [efla_pkg::BS_W-1:0]   divisor,
	output efla_pkg::div_res_t          res
);
	import efla_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [OFF_W-1:0]     quo_q;
	logic [BS_W-1:0]      rem_q;
	logic [BS_W-1:0]      div_q;
	logic [BS_W:0]        shifted;
	logic [BS_W:0]        diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[OFF_W-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(OFF_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[OFF_W-2:0], ge};
			rem_q <= ge ? diff[BS_W-1:0] : shifted[BS_W-1:0];
		end
	end

	assign res.done  = done_q;
	assign res.exact = (rem_q == '0);
	assign res.quo   = quo_q;

endmodule

FILE: hdl/embedded_free_list_block_allocator.sv
// Channel  Handshake            Word
// cfg      cfg_we               cfg_index, cfg_data (num_blocks, block_size)
// in       in_valid / in_ready  action, block_offset, check_links
// out      out_valid / out_ready status, given_offset, given_index, answer,
//                               free_left, all_free
// Per word: allocate reads the head link, then S_ALLOC; unknown actions go to
// S_OUT; reinit writes one link per cycle in S_INIT (n blocks in use); free,
// query use the shared divider in S_DIV (skipped for zero block size), a query
// then walks links; a walking check first clears the visited map, one per cycle.
// Reset clears control only; the link memory holds no list until a reinit.
// A waiting output word holds the next word in S_OUT, with in_ready low there.
module embedded_free_list_block_allocator #(
	parameter int MAX_BLOCKS = 255
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [efla_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [efla_pkg::BS_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [efla_pkg::ACT_W-1:0]       action,
	input  logic [efla_pkg::OFF_W-1:0]       block_offset,
	input  logic                             check_links,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [efla_pkg::ST_W-1:0]        status,
	output logic [efla_pkg::OFF_W-1:0]       given_offset,
	output logic [efla_pkg::IDX_W-1:0]       given_index,
	output logic                             answer,
	output logic [efla_pkg::IDX_W-1:0]       free_left,
	output logic                             all_free
);
	import efla_pkg::*;

	`include "assert_macros.svh"

	localparam int              AW      = $clog2(MAX_BLOCKS);
	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BLOCKS);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_INIT  = 8'b00000010,
		S_DIV   = 8'b00000100,
		S_ALLOC = 8'b00001000,
		S_CLR   = 8'b00010000,
		S_WALK  = 8'b00100000,
		S_VIS   = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;

	// configuration
	logic [IDX_W-1:0] num_blocks_q;
	logic [BS_W-1:0]  block_size_q;

	// list state
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] free_q;

	// per-word working registers
	action_t          act_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] tgt_q;

	// result stage
	status_t          r_status_q;
	logic [OFF_W-1:0] r_off_q;
	logic [IDX_W-1:0] r_idx_q;
	logic             r_ans_q;

	// link memory
	logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
	logic [IDX_W-1:0] link_rd_s1;
	logic             rd_ok_s1;
	logic             mem_re;
	logic             mem_we;
	logic [IDX_W-1:0] mem_ra;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_wd;

	// visited map memory, read at the link just fetched
	logic             vis_mem [MAX_BLOCKS];
	logic             vis_rd_s1;
	logic             vis_re;
	logic             vis_we;
	logic [IDX_W-1:0] vis_wa;
	logic             vis_wd;

	div_res_t         div_res;
	logic             div_start;

	action_t          act_in;
	logic             in_acc;
	logic [IDX_W-1:0] n_used;
	logic [IDX_W-1:0] link_cur;
	logic [IDX_W:0]   cnt_inc;
	logic             walk_end;
	logic             free_zero;
	logic             chk_ans_now;
	logic             chk_walk_go;
	logic             blk_ok;
	logic [IDX_W-1:0] blk;
	logic             q_ans_now;
	logic             q_walk_go;
	logic             w_hit;
	logic             w_go;
	logic             v_go;
	logic [OFF_W-1:0] prod;

	assign act_in   = action_t'(action);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// blocks in use, capped at the memory depth
	assign n_used    = (num_blocks_q > MAX_IDX) ? MAX_IDX : num_blocks_q;
	assign free_zero = (free_q == '0);

	// a link read beyond the memory reads as block zero
	assign link_cur = rd_ok_s1 ? link_rd_s1 : '0;
	assign cnt_inc  = {1'b0, cnt_q} + (IDX_W+1)'(1);
	assign walk_end = cnt_inc >= {1'b0, free_q};

	// check: decisions taken before any link is read
	assign chk_ans_now = (n_used < free_q) || (!free_zero && (head_q >= n_used));
	assign chk_walk_go = !(n_used < free_q) && !free_zero && (head_q < n_used)
		&& check_links && (free_q > IDX_W'(1));

	// free / query: offset must divide exactly and land inside the chunk
	assign blk_ok = div_res.exact && (div_res.quo < {{(OFF_W-IDX_W){1'b0}}, n_used});
	assign blk    = div_res.quo[IDX_W-1:0];
	assign q_ans_now = blk_ok && !free_zero && (head_q == blk);
	assign q_walk_go = blk_ok && !free_zero && (head_q != blk) && (free_q > IDX_W'(1));

	// walk step: link outside the chunk for check, match for query;
	// a check then looks the link up in the visited map in S_VIS
	assign w_hit = (act_q == ACT_CHECK) ? (link_cur >= n_used) : (link_cur == tgt_q);
	assign w_go  = (act_q != ACT_CHECK) && !w_hit && !walk_end;
	assign v_go  = !vis_rd_s1 && !walk_end;

	assign prod = {{(OFF_W-IDX_W){1'b0}}, head_q} * {{(OFF_W-BS_W){1'b0}}, block_size_q};

	assign div_start = (state_q == S_IDLE) && in_acc
		&& ((act_in == ACT_FREE) || (act_in == ACT_QUERY)) && (block_size_q != '0);

	efla_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (block_offset),
		.divisor  (block_size_q),
		.res      (div_res)
	);

	// link and visited memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = head_q;
		mem_we = 1'b0;
		mem_wa = cnt_q;
		mem_wd = cnt_inc[IDX_W-1:0];
		vis_re = 1'b0;
		vis_we = 1'b0;
		vis_wa = cnt_q;
		vis_wd = (cnt_q == head_q);
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && (act_in == ACT_ALLOC) && !free_zero)
					mem_re = 1'b1;
			end
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_DIV: begin
				if (div_res.done && blk_ok) begin
					if (act_q == ACT_FREE) begin
						mem_we = 1'b1;
						mem_wa = blk;
						mem_wd = head_q;
					end else if (q_walk_go) begin
						mem_re = 1'b1;
					end
				end
			end
			S_CLR: begin
				// clear the map, marking the head; fetch the head's link last
				vis_we = 1'b1;
				if (cnt_q == n_used - IDX_W'(1))
					mem_re = 1'b1;
			end
			S_WALK: begin
				if (w_go) begin
					mem_re = 1'b1;
					mem_ra = link_cur;
				end
				if ((act_q == ACT_CHECK) && !w_hit)
					vis_re = 1'b1;
			end
			S_VIS: begin
				if (!vis_rd_s1) begin
					vis_we = 1'b1;
					vis_wa = link_cur;
					vis_wd = 1'b1;
				end
				if (v_go) begin
					mem_re = 1'b1;
					mem_ra = link_cur;
				end
			end
			S_ALLOC, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			link_mem[mem_wa[AW-1:0]] <= mem_wd;
		if (mem_re)
			link_rd_s1 <= link_mem[mem_ra[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (vis_we)
			vis_mem[vis_wa[AW-1:0]] <= vis_wd;
		if (vis_re)
			vis_rd_s1 <= vis_mem[link_cur[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_blocks_q <= 8'd255;
			block_size_q <= 16'd16;
			head_q       <= '0;
			free_q       <= '0;
			rd_ok_s1     <= 1'b0;
			act_q        <= ACT_REINIT;
			cnt_q        <= '0;
			tgt_q        <= '0;
			r_status_q   <= ST_OK;
			r_off_q      <= '0;
			r_idx_q      <= '0;
			r_ans_q      <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NUM_BLOCKS: num_blocks_q <= cfg_data[IDX_W-1:0];
					CFG_BLOCK_SIZE: block_size_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (mem_re)
				rd_ok_s1 <= (mem_ra < MAX_IDX);

			if (out_valid && out_ready)
				out_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						act_q      <= act_in;
						r_status_q <= ST_OK;
						r_off_q    <= '0;
						r_idx_q    <= '0;
						r_ans_q    <= 1'b0;
						cnt_q      <= '0;
						unique case (act_in)
							ACT_REINIT: begin
								if (n_used == '0) begin
									head_q  <= '0;
									free_q  <= '0;
									state_q <= S_OUT;
								end else begin
									state_q <= S_INIT;
								end
							end
							ACT_ALLOC: begin
								if (free_zero) begin
									r_status_q <= ST_NOFREE;
									state_q    <= S_OUT;
								end else begin
									state_q <= S_ALLOC;
								end
							end
							ACT_FREE, ACT_QUERY: begin
								if (block_size_q == '0) begin
									r_status_q <= ST_BADOFF;
									state_q    <= S_OUT;
								end else begin
									state_q <= S_DIV;
								end
							end
							ACT_CHECK: begin
								r_ans_q <= chk_ans_now;
								state_q <= chk_walk_go ? S_CLR : S_OUT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_INIT: begin
					// link i -> i+1 written this cycle
					if (cnt_q == n_used - IDX_W'(1)) begin
						head_q  <= '0;
						free_q  <= n_used;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_inc[IDX_W-1:0];
					end
				end
				S_ALLOC: begin
					r_idx_q <= head_q;
					r_off_q <= prod;
					head_q  <= link_cur;
					free_q  <= free_q - IDX_W'(1);
					state_q <= S_OUT;
				end
				S_DIV: begin
					if (div_res.done) begin
						if (!blk_ok) begin
							r_status_q <= ST_BADOFF;
							state_q    <= S_OUT;
						end else if (act_q == ACT_FREE) begin
							// double free is not caught: block is pushed again
							head_q <= blk;
							if (free_q != '1)
								free_q <= free_q + IDX_W'(1);
							state_q <= S_OUT;
						end else begin
							tgt_q   <= blk;
							r_ans_q <= q_ans_now;
							cnt_q   <= IDX_W'(1);
							state_q <= q_walk_go ? S_WALK : S_OUT;
						end
					end
				end
				S_CLR: begin
					if (cnt_q == n_used - IDX_W'(1)) begin
						cnt_q   <= IDX_W'(1);
						state_q <= S_WALK;
					end else begin
						cnt_q <= cnt_inc[IDX_W-1:0];
					end
				end
				S_WALK: begin
					if (w_hit) begin
						r_ans_q <= 1'b1;
						state_q <= S_OUT;
					end else if (act_q == ACT_CHECK) begin
						state_q <= S_VIS;
					end else begin
						cnt_q <= cnt_inc[IDX_W-1:0];
						if (walk_end)
							state_q <= S_OUT;
					end
				end
				S_VIS: begin
					// revisit means a loop in the list
					if (vis_rd_s1) begin
						r_ans_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						cnt_q   <= cnt_inc[IDX_W-1:0];
						state_q <= walk_end ? S_OUT : S_WALK;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && (!out_valid || out_ready)) begin
			status       <= r_status_q;
			given_offset <= r_off_q;
			given_index  <= r_idx_q;
			answer       <= r_ans_q;
			free_left    <= free_q;
			all_free     <= (free_q == num_blocks_q);
		end
	end

	`ASSERT_NXT(a_alloc_dec, clk, arst_n, state_q == S_ALLOC, free_q == $past(free_q) - 8'd1)
	`ASSERT_IMP(a_walk_bound, clk, arst_n, (state_q == S_WALK) || (state_q == S_VIS), cnt_q < free_q)
	`ASSERT_IMP(a_out_src, clk, arst_n, $rose(out_valid), $past(state_q == S_OUT))
	`ASSERT_IMP(a_div_busy, clk, arst_n, div_res.done, state_q == S_DIV)

endmodule

FILE: tb/tb.sv
module tb;
	import efla_pkg::*;

	localparam int LINK_DEPTH  = 255;
	localparam int STUCK_LIMIT = 3000;  // idle cycles with no word moving on either side
	localparam int TAIL_CYCLES = 400;   // cycles to linger after the final drain
	localparam int HOLD_CYCLES = 200;   // long receiver hold-off for the fill-up test
	localparam int PHASE_ITEMS = 115;

	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;  // unused codes, block ignores them
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
	localparam logic [OFF_W-1:0] OFF_TOP      = '1;

	// One result word as the block should return it.
	typedef struct packed {
		status_t          st;
		logic [OFF_W-1:0] goff;
		logic [IDX_W-1:0] gidx;
		logic             ans;
		logic [IDX_W-1:0] left;
		logic             allf;
	} alloc_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BS_W-1:0]      cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [ACT_W-1:0]     action;
	logic [OFF_W-1:0]     block_offset;
	logic                 check_links;
	logic                 out_valid;
	logic                 out_ready;
	logic [ST_W-1:0]      status;
	logic [OFF_W-1:0]     given_offset;
	logic [IDX_W-1:0]     given_index;
	logic                 answer;
	logic [IDX_W-1:0]     free_left;
	logic                 all_free;

	// Shadow of the allocator: link table, head, free count and both registers.
	logic [IDX_W-1:0] link_copy [0:LINK_DEPTH-1];
	logic [IDX_W-1:0] head_copy  = '0;
	logic [IDX_W-1:0] free_copy  = '0;   // reset leaves the free list empty
	logic [IDX_W-1:0] blocks_cfg = 8'd255;
	logic [BS_W-1:0]  size_cfg   = 16'd16;

	alloc_word_t      pending_words [$];
	alloc_word_t      due;
	logic [IDX_W-1:0] lent_blocks [$];   // blocks handed out and not yet given back

	int fail_count   = 0;
	int words_seen   = 0;
	int stuck_cycles = 0;
	int gap_max      = 11;
	int stall_max    = 11;
	int hold_req     = 0;

	embedded_free_list_block_allocator #(.MAX_BLOCKS(LINK_DEPTH)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- shadow model

	function automatic logic [IDX_W-1:0] link_at(input logic [IDX_W-1:0] i);
		// past the end of the table reads as zero
		return (i < LINK_DEPTH) ? link_copy[i] : '0;
	endfunction

	function automatic logic [OFF_W-1:0] block_addr(input logic [IDX_W-1:0] blk);
		logic [31:0] prod;
		prod = 32'(blk) * 32'(size_cfg);
		return prod[OFF_W-1:0];
	endfunction

	// Offset to block number; fails on zero size, misalignment or out of range.
	function automatic bit offset_block(input logic [OFF_W-1:0] off,
			output logic [IDX_W-1:0] blk);
		logic [OFF_W-1:0] q;
		blk = '0;
		if (size_cfg == '0 || (off % size_cfg) != '0)
			return 1'b0;
		q = off / size_cfg;
		if (q >= blocks_cfg)
			return 1'b0;
		blk = q[IDX_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic list_corrupt(input logic walk);
		bit               seen [0:LINK_DEPTH-1];
		logic [IDX_W-1:0] idx;
		int               cc;
		seen = '{default: 1'b0};
		if (blocks_cfg < free_copy)
			return 1'b1;
		if (free_copy == '0)
			return 1'b0;
		if (head_copy >= blocks_cfg)
			return 1'b1;
		if (!walk)
			return 1'b0;
		// follow free_copy - 1 links; leaving the chunk or a loop back is corruption
		idx = head_copy;
		seen[idx] = 1'b1;
		for (cc = 1; cc < free_copy; cc++) begin
			idx = link_at(idx);
			if (idx >= blocks_cfg || seen[idx])
				return 1'b1;
			seen[idx] = 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic block_is_free(input logic [IDX_W-1:0] blk);
		logic [IDX_W-1:0] idx;
		int               cc;
		if (free_copy == '0)
			return 1'b0;
		idx = head_copy;
		if (idx == blk)
			return 1'b1;
		for (cc = 1; cc < free_copy; cc++) begin
			idx = link_at(idx);
			if (idx == blk)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Applies one accepted word to the shadow and returns the result it must give.
	function automatic alloc_word_t forecast_word(input logic [ACT_W-1:0] act,
			input logic [OFF_W-1:0] off, input logic walk);
		alloc_word_t      w;
		logic [IDX_W-1:0] blk;
		int               i;
		w = '0;
		w.st = ST_OK;
		case (act)
			ACT_REINIT: begin
				for (i = 0; i < blocks_cfg; i++)
					link_copy[i] = IDX_W'(i + 1);
				head_copy = '0;
				free_copy = blocks_cfg;
			end
			ACT_ALLOC: begin
				if (free_copy == '0) begin
					w.st = ST_NOFREE;
				end else begin
					// head is handed out as it stands, even if it lies outside the chunk
					w.gidx = head_copy;
					w.goff = block_addr(head_copy);
					head_copy = link_at(head_copy);
					free_copy = free_copy - 8'd1;
				end
			end
			ACT_FREE: begin
				if (!offset_block(off, blk)) begin
					w.st = ST_BADOFF;
				end else begin
					// double free goes undetected; count saturates
					link_copy[blk] = head_copy;
					head_copy = blk;
					if (free_copy != 8'd255)
						free_copy = free_copy + 8'd1;
				end
			end
			ACT_CHECK: begin
				w.ans = list_corrupt(walk);
			end
			ACT_QUERY: begin
				if (!offset_block(off, blk))
					w.st = ST_BADOFF;
				else
					w.ans = block_is_free(blk);
			end
			default: ;
		endcase
		w.left = free_copy;
		w.allf = (free_copy == blocks_cfg);
		return w;
	endfunction

	// ---------------------------------------------------------------- stimulus side

	// Offers one word, waits for it to be taken, then logs the expected result.
	// Valid is only dropped when a gap is drawn, so back-to-back words keep it high.
	task automatic send_word(input logic [ACT_W-1:0] act, input logic [OFF_W-1:0] off,
			input logic walk, output alloc_word_t w);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		block_offset <= off;
		check_links  <= walk;
		do @(posedge clk); while (in_ready !== 1'b1);
		w = forecast_word(act, off, walk);
		pending_words.push_back(w);
	endtask

	// Sender stops and waits until every expected word is back.
	task automatic drain_words();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Registers only change with the block idle.
	task automatic set_geometry(input int n, input int bs);
		drain_words();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NUM_BLOCKS;
		cfg_data  <= BS_W'(n);
		@(posedge clk);
		cfg_index <= CFG_BLOCK_SIZE;
		cfg_data  <= BS_W'(bs);
		@(posedge clk);
		cfg_we    <= 1'b0;
		blocks_cfg = IDX_W'(n);
		size_cfg   = BS_W'(bs);
	endtask

	// Mostly well-formed traffic: reinits, allocations, returns of lent blocks,
	// queries and checks; some bad offsets, double frees and spare codes on top.
	task automatic random_word(output bit counted);
		alloc_word_t      w;
		logic [IDX_W-1:0] blk;
		logic [OFF_W-1:0] junk;
		logic             walk;
		int               pick;
		int               j;
		junk    = OFF_W'($urandom);
		walk    = 1'($urandom);
		blk     = IDX_W'($urandom_range(0, blocks_cfg - 1));
		pick    = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 4) begin
			send_word(ACT_REINIT, junk, walk, w);
			lent_blocks.delete();
		end else if (pick < 40 || (pick < 70 && lent_blocks.size() == 0)) begin
			send_word(ACT_ALLOC, junk, walk, w);
			if (w.st == ST_OK)
				lent_blocks.push_back(w.gidx);
		end else if (pick < 70) begin
			j = $urandom_range(0, lent_blocks.size() - 1);
			blk = lent_blocks[j];
			lent_blocks.delete(j);
			send_word(ACT_FREE, block_addr(blk), walk, w);
		end else if (pick < 80) begin
			send_word(ACT_QUERY, block_addr(blk), walk, w);
		end else if (pick < 88) begin
			send_word(ACT_CHECK, junk, walk, w);
		end else if (pick < 97) begin
			case ($urandom_range(0, 3))
				0: send_word(ACT_FREE, junk, walk, w);
				1: send_word(ACT_QUERY, junk, walk, w);
				2: send_word(ACT_FREE, block_addr(blk) + 1'b1, walk, w);
				default: send_word(ACT_FREE, block_addr(blk), walk, w);  // maybe a double free
			endcase
		end else begin
			send_word(ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), junk, walk, w);
			counted = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- tests

	// Before any reinit: empty chunk, nothing may touch the link table.
	task automatic test_idle_after_reset();
		alloc_word_t w;
		send_word(ACT_ALLOC, '0, 1'b0, w);
		send_word(ACT_QUERY, '0, 1'b1, w);
		send_word(ACT_CHECK, OFF_TOP, 1'b1, w);
		send_word(ACT_SPARE_HI, OFF_TOP, 1'b1, w);
	endtask

	// Reset geometry: 255 blocks of 16 bytes.
	task automatic test_list_basics();
		alloc_word_t w;
		send_word(ACT_REINIT, '0, 1'b0, w);
		send_word(ACT_ALLOC, '0, 1'b0, w);
		send_word(ACT_ALLOC, '0, 1'b0, w);
		send_word(ACT_QUERY, 24'd16, 1'b0, w);    // lent out
		send_word(ACT_QUERY, 24'd32, 1'b0, w);    // now the head
		send_word(ACT_FREE, 24'd8, 1'b0, w);      // misaligned
		send_word(ACT_FREE, 24'd4080, 1'b0, w);   // one past the last block
		send_word(ACT_FREE, OFF_TOP, 1'b1, w);
		send_word(ACT_FREE, 24'd16, 1'b0, w);
		send_word(ACT_CHECK, '0, 1'b1, w);        // clean full walk
		send_word(ACT_FREE, 24'd16, 1'b0, w);     // double free: self loop
		send_word(ACT_CHECK, '0, 1'b1, w);
		send_word(ACT_FREE, '0, 1'b0, w);         // count saturates
		send_word(ACT_CHECK, '0, 1'b0, w);
	endtask

	// Smallest and largest geometry, then a head left outside a shrunk chunk.
	task automatic test_geometry_extremes();
		alloc_word_t w;
		set_geometry(1, 1);
		send_word(ACT_REINIT, '0, 1'b1, w);
		send_word(ACT_ALLOC, '0, 1'b0, w);
		send_word(ACT_ALLOC, '0, 1'b0, w);        // nothing left
		send_word(ACT_FREE, 24'd1, 1'b0, w);
		send_word(ACT_FREE, '0, 1'b0, w);
		send_word(ACT_QUERY, '0, 1'b1, w);
		set_geometry(255, 65535);
		send_word(ACT_REINIT, '0, 1'b0, w);
		send_word(ACT_ALLOC, '0, 1'b0, w);
		send_word(ACT_ALLOC, '0, 1'b0, w);
		set_geometry(2, 65535);
		send_word(ACT_CHECK, '0, 1'b0, w);        // count above chunk size
		send_word(ACT_ALLOC, '0, 1'b0, w);        // head 2 goes out regardless
	endtask

	// Phases of random traffic over several geometries; zero entries are drawn.
	task automatic test_random_traffic();
		int          n_tab  [8] = '{255, 8, 1, 255, 3, 0, 60, 255};
		int          bs_tab [8] = '{16, 1, 1, 65535, 4096, 0, 3, 1};
		int          p;
		int          n;
		int          bs;
		int          done;
		bit          counted;
		alloc_word_t w;
		for (p = 0; p < 8; p++) begin
			n  = (n_tab[p] == 0) ? $urandom_range(1, 255) : n_tab[p];
			bs = (bs_tab[p] == 0) ? $urandom_range(1, 65535) : bs_tab[p];
			set_geometry(n, bs);
			// both idle, neither, sender only, receiver only
			case (p % 4)
				0: begin gap_max = 11; stall_max = 11; end
				1: begin gap_max = 0;  stall_max = 0;  end
				2: begin gap_max = 11; stall_max = 0;  end
				default: begin gap_max = 0; stall_max = 11; end
			endcase
			send_word(ACT_REINIT, OFF_W'($urandom), 1'($urandom), w);
			lent_blocks.delete();
			done = 0;
			while (done < PHASE_ITEMS) begin
				random_word(counted);
				done += counted;
			end
		end
	endtask

	// Receiver sits out a long stretch while words keep coming, so the block
	// backs up and drops in_ready; then the sender waits for everything.
	task automatic test_backpressure();
		bit counted;
		int k;
		set_geometry(255, 16);
		gap_max   = 0;
		stall_max = 0;
		hold_req  = HOLD_CYCLES;
		for (k = 0; k < 30; k++)
			random_word(counted);
		drain_words();
		gap_max   = 11;
		stall_max = 11;
	endtask

	// ---------------------------------------------------------------- result side

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		fail_count++;
	endtask

	task automatic cmp_field(input string name, input logic [OFF_W-1:0] got,
			input logic [OFF_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s: got %0h, want %0h",
				words_seen, name, got, want));
	endtask

	// Receiver: random stall per word, or one long hold-off when requested.
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (hold_req > 0) ? hold_req : $urandom_range(0, stall_max);
			hold_req = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Every word taken is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_seen = words_seen + 1;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("word %0d arrived with nothing expected",
					words_seen));
			end else begin
				due = pending_words.pop_front();
				cmp_field("status", status, due.st);
				cmp_field("given_offset", given_offset, due.goff);
				cmp_field("given_index", given_index, due.gidx);
				cmp_field("answer", answer, due.ans);
				cmp_field("free_left", free_left, due.left);
				cmp_field("all_free", all_free, due.allf);
			end
		end
	end

	// Watchdog: cycles since any word moved.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stuck_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (arst_n === 1'b1);
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("ERROR: no word moved for %0d cycles", STUCK_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_NUM_BLOCKS;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		action       <= ACT_REINIT;
		block_offset <= '0;
		check_links  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_list_basics();
		test_geometry_extremes();
		test_random_traffic();
		test_backpressure();

		// all back; linger to catch stray words
		drain_words();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/efla_pkg.sv
hdl/efla_div.sv
hdl/embedded_free_list_block_allocator.sv
tb/tb.sv
